/* src/jsu_pkg.sv */
package jsu_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] STATUS_NONE      = 3'd0;
   localparam logic [2:0] STATUS_BAD_HEX   = 3'd1;
   localparam logic [2:0] STATUS_BAD_SURR  = 3'd2;
   localparam logic [2:0] STATUS_BAD_ESC   = 3'd3;
   localparam logic [2:0] STATUS_NO_CLOSE  = 3'd4;
   localparam logic [2:0] STATUS_CTRL_CHAR = 3'd5;
   localparam logic [2:0] STATUS_NO_OPEN   = 3'd6;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSL   = 8'h5C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [2:0]                  count;
      logic [1:0]                  kind;
      logic [2:0]                  status;
   } grp_type;

   // bit 4 set: valid hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_digit(logic [7:0] b);
      logic [4:0] r;
      r = '0;
      priority if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else begin
         r = '0;
      end
      return r;
   endfunction

   function automatic grp_type error_group(logic [2:0] status);
      grp_type g;
      g        = '0;
      g.count  = 3'd1;
      g.kind   = KIND_ERROR;
      g.status = status;
      return g;
   endfunction

   function automatic grp_type data_group(logic [7:0] b);
      grp_type g;
      g         = '0;
      g.count   = 3'd1;
      g.kind    = KIND_DATA;
      g.data[0] = b;
      return g;
   endfunction

   function automatic grp_type utf8_encode(logic [20:0] cp);
      grp_type g;
      g      = '0;
      g.kind = KIND_DATA;
      priority if (cp <= 21'h7F) begin
         g.data[0] = cp[7:0];
         g.count   = 3'd1;
      end else if (cp <= 21'h7FF) begin
         g.data[0] = {3'b110, cp[10:6]};
         g.data[1] = {2'b10, cp[5:0]};
         g.count   = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         g.data[0] = {4'b1110, cp[15:12]};
         g.data[1] = {2'b10, cp[11:6]};
         g.data[2] = {2'b10, cp[5:0]};
         g.count   = 3'd3;
      end else begin
         g.data[0] = {5'b11110, cp[20:18]};
         g.data[1] = {2'b10, cp[17:12]};
         g.data[2] = {2'b10, cp[11:6]};
         g.data[3] = {2'b10, cp[5:0]};
         g.count   = 3'd4;
      end
      return g;
   endfunction

endpackage

/* src/jsu_decode.sv */
module jsu_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  logic [7:0]       text_byte,
   output jsu_pkg::grp_type grp
);

   localparam logic [3:0] MODE_IDLE  = 4'd0;
   localparam logic [3:0] MODE_BODY  = 4'd1;
   localparam logic [3:0] MODE_ESC   = 4'd2;
   localparam logic [3:0] MODE_HEXA0 = 4'd3;
   localparam logic [3:0] MODE_HEXA1 = 4'd4;
   localparam logic [3:0] MODE_HEXA2 = 4'd5;
   localparam logic [3:0] MODE_HEXA3 = 4'd6;
   localparam logic [3:0] MODE_BSL2  = 4'd7;
   localparam logic [3:0] MODE_U2    = 4'd8;
   localparam logic [3:0] MODE_HEXB0 = 4'd9;
   localparam logic [3:0] MODE_HEXB1 = 4'd10;
   localparam logic [3:0] MODE_HEXB2 = 4'd11;
   localparam logic [3:0] MODE_HEXB3 = 4'd12;

   logic [3:0]  mode_ff, mode_in, mode_calc;
   logic [15:0] hex_ff, hex_in, hex_calc;
   logic [15:0] surr_ff, surr_in, surr_calc;
   logic [4:0]  digit;
   logic [15:0] acc_new;
   logic [20:0] pair_cp;

   assign digit   = jsu_pkg::hex_digit(text_byte);
   assign acc_new = {hex_ff[11:0], digit[3:0]};
   assign pair_cp = {1'b0, surr_ff[9:0], acc_new[9:0]} + jsu_pkg::SUPP_BASE;

   always_comb begin
      mode_calc = mode_ff;
      hex_calc  = hex_ff;
      surr_calc = surr_ff;
      grp       = '0;
      unique case (mode_ff)
         MODE_BODY: begin
            priority if (text_byte == jsu_pkg::CHAR_QUOTE) begin
               mode_calc = MODE_IDLE;
               grp.count = 3'd1;
               grp.kind  = jsu_pkg::KIND_DONE;
            end else if (text_byte == jsu_pkg::CHAR_BSL) begin
               mode_calc = MODE_ESC;
            end else if (text_byte == 8'h00) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_NO_CLOSE);
            end else if (text_byte < jsu_pkg::CHAR_SPACE) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_CTRL_CHAR);
            end else begin
               grp = jsu_pkg::data_group(text_byte);
            end
         end
         MODE_ESC: begin
            mode_calc = MODE_BODY;
            unique case (text_byte)
               jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSL, jsu_pkg::CHAR_SLASH:
                  grp = jsu_pkg::data_group(text_byte);
               8'h62: grp = jsu_pkg::data_group(8'h08);
               8'h66: grp = jsu_pkg::data_group(8'h0C);
               8'h6E: grp = jsu_pkg::data_group(8'h0A);
               8'h72: grp = jsu_pkg::data_group(8'h0D);
               8'h74: grp = jsu_pkg::data_group(8'h09);
               jsu_pkg::CHAR_U: begin
                  hex_calc  = '0;
                  mode_calc = MODE_HEXA0;
               end
               default: begin
                  mode_calc = MODE_IDLE;
                  hex_calc  = '0;
                  surr_calc = '0;
                  grp       = jsu_pkg::error_group(jsu_pkg::STATUS_BAD_ESC);
               end
            endcase
         end
         MODE_HEXA0, MODE_HEXA1, MODE_HEXA2, MODE_HEXA3: begin
            priority if (!digit[4]) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_BAD_HEX);
            end else if (mode_ff != MODE_HEXA3) begin
               hex_calc  = acc_new;
               mode_calc = mode_ff + 4'd1;
            end else if (acc_new >= jsu_pkg::HIGH_SURR_LO &&
                         acc_new <= jsu_pkg::HIGH_SURR_HI) begin
               hex_calc  = acc_new;
               surr_calc = acc_new;
               mode_calc = MODE_BSL2;
            end else begin
               hex_calc  = acc_new;
               mode_calc = MODE_BODY;
               grp       = jsu_pkg::utf8_encode({5'd0, acc_new});
            end
         end
         MODE_BSL2: begin
            if (text_byte != jsu_pkg::CHAR_BSL) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_BAD_SURR);
            end else begin
               mode_calc = MODE_U2;
            end
         end
         MODE_U2: begin
            if (text_byte != jsu_pkg::CHAR_U) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_BAD_SURR);
            end else begin
               hex_calc  = '0;
               mode_calc = MODE_HEXB0;
            end
         end
         MODE_HEXB0, MODE_HEXB1, MODE_HEXB2, MODE_HEXB3: begin
            priority if (!digit[4]) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_BAD_HEX);
            end else if (mode_ff != MODE_HEXB3) begin
               hex_calc  = acc_new;
               mode_calc = mode_ff + 4'd1;
            end else if (acc_new < jsu_pkg::LOW_SURR_LO ||
                         acc_new > jsu_pkg::LOW_SURR_HI) begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_BAD_SURR);
            end else begin
               hex_calc  = acc_new;
               mode_calc = MODE_BODY;
               grp       = jsu_pkg::utf8_encode(pair_cp);
            end
         end
         default: begin
            if (text_byte == jsu_pkg::CHAR_QUOTE) begin
               mode_calc = MODE_BODY;
               hex_calc  = '0;
               surr_calc = '0;
            end else begin
               mode_calc = MODE_IDLE;
               hex_calc  = '0;
               surr_calc = '0;
               grp       = jsu_pkg::error_group(jsu_pkg::STATUS_NO_OPEN);
            end
         end
      endcase
   end

   always_comb begin
      mode_in = commit ? mode_calc : mode_ff;
      hex_in  = commit ? hex_calc  : hex_ff;
      surr_in = commit ? surr_calc : surr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hex_ff  <= '0;
         surr_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         hex_ff  <= hex_in;
         surr_ff <= surr_in;
      end
   end

endmodule

/* src/jsu_serial.sv */
module jsu_serial (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  jsu_pkg::grp_type grp,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);

   logic             valid_ff, valid_in;
   jsu_pkg::grp_type grp_ff, grp_in;
   logic [1:0]       idx_ff, idx_in;
   logic             is_last;
   logic             xfer;

   assign is_last      = ({1'b0, idx_ff} == (grp_ff.count - 3'd1));
   assign xfer         = valid_ff && !rsp_stall;
   assign free         = !valid_ff || (xfer && is_last);
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = grp_ff.data[idx_ff];
   assign rsp_kind     = grp_ff.kind;
   assign rsp_status   = grp_ff.status;
   assign rsp_last     = is_last;

   always_comb begin
      valid_in = valid_ff;
      grp_in   = grp_ff;
      idx_in   = idx_ff;
      priority if (load) begin
         valid_in = 1'b1;
         grp_in   = grp;
         idx_in   = '0;
      end else if (xfer) begin
         valid_in = !is_last;
         idx_in   = idx_ff + 2'd1;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

endmodule

/* src/json_string_unescape_utf8.sv */
// JSON string unescaper: one byte of JSON text per transfer on req_, starting at the
// opening quote. Each byte yields zero to four rsp_ transfers (UTF-8 data bytes with
// rsp_kind 0, a completion with rsp_kind 1, or an error with rsp_kind 2 and a code on
// rsp_status); rsp_last marks the final one for that byte. A byte is registered, decoded
// combinationally into a result group, and the group is drained one transfer per cycle
// while rsp_stall is low, so the block then takes one byte per cycle if each byte gives
// at most one result; a byte with a longer group holds the input until the group drains
// through the single output port. After an error the block waits for a new opening quote.
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             accept;
   logic             advance;
   logic             free;
   jsu_pkg::grp_type grp;

   assign advance   = in_valid_ff && (free || (grp.count == 3'd0));
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in  = accept ? req_text_byte : in_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   jsu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .commit    (advance),
      .text_byte (in_byte_ff),
      .grp       (grp)
   );

   jsu_serial u_serial (
      .clock        (clock),
      .reset        (reset),
      .load         (advance && (grp.count != 3'd0)),
      .grp          (grp),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

/* verif/jsu_decode_check.sv */
`timescale 1ns / 100ps

module jsu_decode_check
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_kind,
   input  logic [2:0] rsp_status,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);

   typedef enum logic [3:0] {
      MODE_IDLE = 4'd0,
      MODE_BODY,
      MODE_ESC,
      MODE_HEX1,
      MODE_HEX2,
      MODE_HEX3,
      MODE_HEX4,
      MODE_BSL2,
      MODE_U2,
      MODE_LOW1,
      MODE_LOW2,
      MODE_LOW3,
      MODE_LOW4
   } dec_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] status;
      logic       last;
   } decoded_type;

   decoded_type  decoded_q[$];
   decoded_type  want;
   dec_mode_type dec_mode  = MODE_IDLE;
   logic [15:0]  hex_acc   = '0;
   logic [15:0]  high_surr = '0;
   int           errs;
   int           fail_total = 0;
   int           pending_total = 0;

   assign fail_count = fail_total;
   assign pending    = pending_total;

   function automatic int nibble_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      return -1;
   endfunction

   task automatic put_expected(logic [7:0] data, logic [1:0] kind, logic [2:0] status,
                               logic last);
      decoded_type r;
      r.out_byte = data;
      r.kind     = kind;
      r.status   = status;
      r.last     = last;
      decoded_q.push_back(r);
   endtask

   task automatic abort_string(logic [2:0] status);
      dec_mode  = MODE_IDLE;
      hex_acc   = '0;
      high_surr = '0;
      put_expected(8'h00, KIND_ERROR, status, 1'b1);
   endtask

   task automatic put_code_point(logic [20:0] cp);
      logic [7:0] seq [4];
      int         n;
      if (cp < 21'h80) begin
         seq[0] = cp[7:0];
         n = 1;
      end else if (cp < 21'h800) begin
         seq[0] = 8'hC0 | 8'(cp[10:6]);
         seq[1] = 8'h80 | 8'(cp[5:0]);
         n = 2;
      end else if (cp < 21'h10000) begin
         seq[0] = 8'hE0 | 8'(cp[15:12]);
         seq[1] = 8'h80 | 8'(cp[11:6]);
         seq[2] = 8'h80 | 8'(cp[5:0]);
         n = 3;
      end else begin
         seq[0] = 8'hF0 | 8'(cp[20:18]);
         seq[1] = 8'h80 | 8'(cp[17:12]);
         seq[2] = 8'h80 | 8'(cp[11:6]);
         seq[3] = 8'h80 | 8'(cp[5:0]);
         n = 4;
      end
      for (int i = 0; i < n; i++) begin
         put_expected(seq[i], KIND_DATA, STATUS_NONE, i == n - 1);
      end
   endtask

   task automatic unescape_byte(logic [7:0] b);
      int          h;
      logic [20:0] cp;
      case (dec_mode)
         MODE_BODY: begin
            if (b == CHAR_QUOTE) begin
               dec_mode = MODE_IDLE;
               put_expected(8'h00, KIND_DONE, STATUS_NONE, 1'b1);
            end else if (b == CHAR_BSL) begin
               dec_mode = MODE_ESC;
            end else if (b == 8'h00) begin
               abort_string(STATUS_NO_CLOSE);
            end else if (b < CHAR_SPACE) begin
               abort_string(STATUS_CTRL_CHAR);
            end else begin
               put_expected(b, KIND_DATA, STATUS_NONE, 1'b1);
            end
         end
         MODE_ESC: begin
            dec_mode = MODE_BODY;
            case (b)
               CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: put_expected(b, KIND_DATA, STATUS_NONE, 1'b1);
               "b": put_expected(8'h08, KIND_DATA, STATUS_NONE, 1'b1);
               "f": put_expected(8'h0C, KIND_DATA, STATUS_NONE, 1'b1);
               "n": put_expected(8'h0A, KIND_DATA, STATUS_NONE, 1'b1);
               "r": put_expected(8'h0D, KIND_DATA, STATUS_NONE, 1'b1);
               "t": put_expected(8'h09, KIND_DATA, STATUS_NONE, 1'b1);
               CHAR_U: begin
                  hex_acc  = '0;
                  dec_mode = MODE_HEX1;
               end
               default: abort_string(STATUS_BAD_ESC);
            endcase
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
            h = nibble_of(b);
            if (h < 0) begin
               abort_string(STATUS_BAD_HEX);
            end else begin
               hex_acc = {hex_acc[11:0], 4'(h)};
               if (dec_mode != MODE_HEX4) begin
                  dec_mode = dec_mode_type'(dec_mode + 4'd1);
               end else if (hex_acc >= HIGH_SURR_LO && hex_acc <= HIGH_SURR_HI) begin
                  high_surr = hex_acc;
                  dec_mode  = MODE_BSL2;
               end else begin
                  dec_mode = MODE_BODY;
                  put_code_point({5'b0, hex_acc});
               end
            end
         end
         MODE_BSL2: begin
            if (b != CHAR_BSL) abort_string(STATUS_BAD_SURR);
            else dec_mode = MODE_U2;
         end
         MODE_U2: begin
            if (b != CHAR_U) begin
               abort_string(STATUS_BAD_SURR);
            end else begin
               hex_acc  = '0;
               dec_mode = MODE_LOW1;
            end
         end
         MODE_LOW1, MODE_LOW2, MODE_LOW3, MODE_LOW4: begin
            h = nibble_of(b);
            if (h < 0) begin
               abort_string(STATUS_BAD_HEX);
            end else begin
               hex_acc = {hex_acc[11:0], 4'(h)};
               if (dec_mode != MODE_LOW4) begin
                  dec_mode = dec_mode_type'(dec_mode + 4'd1);
               end else if (hex_acc < LOW_SURR_LO || hex_acc > LOW_SURR_HI) begin
                  abort_string(STATUS_BAD_SURR);
               end else begin
                  dec_mode = MODE_BODY;
                  cp = ((21'(high_surr - HIGH_SURR_LO) << 10) | 21'(hex_acc - LOW_SURR_LO))
                       + SUPP_BASE;
                  put_code_point(cp);
               end
            end
         end
         default: begin
            if (b == CHAR_QUOTE) begin
               dec_mode  = MODE_BODY;
               hex_acc   = '0;
               high_surr = '0;
            end else begin
               abort_string(STATUS_NO_OPEN);
            end
         end
      endcase
   endtask

   task automatic compare_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      errs = 0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected transfer: out_byte %0h kind %0h status %0h last %0h",
                      rsp_out_byte, rsp_kind, rsp_status, rsp_last);
               errs++;
            end else begin
               want = decoded_q.pop_front();
               compare_field("rsp_out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
               compare_field("rsp_kind", 32'(want.kind), 32'(rsp_kind));
               compare_field("rsp_status", 32'(want.status), 32'(rsp_status));
               compare_field("rsp_last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall) unescape_byte(req_text_byte);
      end
      pending_total <= decoded_q.size();
      fail_total    <= fail_total + errs;
   end

endmodule

/* verif/json_string_unescape_utf8_test.sv */
`timescale 1ns / 100ps

module json_string_unescape_utf8_test;
   import jsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_text_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_status;
   logic       rsp_last;
   int         fail_count;
   int         pending;

   logic [7:0] text_q[$];
   int         bytes_sent    = 0;
   int         send_gap_pct  = 34;
   int         recv_gap_pct  = 72;
   bit         hold_off_req  = 1'b0;
   int         quiet_cycles  = 0;

   json_string_unescape_utf8 u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   jsu_decode_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_gap_pct);
         end
      end
   end

   function automatic bit is_hex_char(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
   endfunction

   task automatic put_byte(logic [7:0] b);
      text_q.push_back(b);
   endtask

   task automatic put_hex_digits(logic [15:0] v, int count);
      logic [3:0] nib;
      for (int i = 3; i > 3 - count; i--) begin
         nib = v[4*i +: 4];
         if (nib < 4'd10) put_byte("0" + nib);
         else if ($urandom_range(1)) put_byte("A" + nib - 4'd10);
         else put_byte("a" + nib - 4'd10);
      end
   endtask

   task automatic put_u_escape(logic [15:0] v);
      put_byte(CHAR_BSL);
      put_byte(CHAR_U);
      put_hex_digits(v, 4);
   endtask

   task automatic put_bad_hex_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (is_hex_char(b));
      put_byte(b);
   endtask

   task automatic build_string();
      int          tokens;
      int          pick;
      logic [7:0]  b;
      logic [15:0] v;
      if ($urandom_range(99) < 5) begin
         do b = 8'($urandom_range(255)); while (b == CHAR_QUOTE);
         put_byte(b);
      end
      put_byte(CHAR_QUOTE);
      tokens = $urandom_range(8);
      repeat (tokens) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            // malformed content
            case ($urandom_range(6))
               0: put_byte(8'($urandom_range(8'h1F)));
               1: begin
                  put_byte(CHAR_BSL);
                  do b = 8'($urandom_range(255));
                  while (b == CHAR_QUOTE || b == CHAR_BSL || b == CHAR_SLASH || b == "b" ||
                         b == "f" || b == "n" || b == "r" || b == "t" || b == CHAR_U);
                  put_byte(b);
               end
               2: begin
                  put_byte(CHAR_BSL);
                  put_byte(CHAR_U);
                  put_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
                  put_bad_hex_char();
               end
               3: begin
                  put_u_escape(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
                  do b = 8'($urandom_range(255)); while (b == CHAR_BSL);
                  put_byte(b);
               end
               4: begin
                  put_u_escape(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
                  put_byte(CHAR_BSL);
                  do b = 8'($urandom_range(255)); while (b == CHAR_U);
                  put_byte(b);
               end
               5: begin
                  put_u_escape(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
                  do v = 16'($urandom_range(16'hFFFF));
                  while (v >= LOW_SURR_LO && v <= LOW_SURR_HI);
                  put_u_escape(v);
               end
               default: begin
                  put_u_escape(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
                  put_byte(CHAR_BSL);
                  put_byte(CHAR_U);
                  put_hex_digits(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)),
                                 $urandom_range(3));
                  put_bad_hex_char();
               end
            endcase
         end else if (pick < 45) begin
            do b = 8'($urandom_range(CHAR_SPACE, 8'hFF));
            while (b == CHAR_QUOTE || b == CHAR_BSL);
            put_byte(b);
         end else if (pick < 60) begin
            put_byte(CHAR_BSL);
            case ($urandom_range(7))
               0: put_byte(CHAR_QUOTE);
               1: put_byte(CHAR_BSL);
               2: put_byte(CHAR_SLASH);
               3: put_byte("b");
               4: put_byte("f");
               5: put_byte("n");
               6: put_byte("r");
               default: put_byte("t");
            endcase
         end else if (pick < 80) begin
            if ($urandom_range(3) == 0) begin
               case ($urandom_range(9))
                  0: v = 16'h0000;
                  1: v = 16'h007F;
                  2: v = 16'h0080;
                  3: v = 16'h07FF;
                  4: v = 16'h0800;
                  5: v = 16'hD7FF;
                  6: v = LOW_SURR_LO;
                  7: v = LOW_SURR_HI;
                  8: v = 16'hE000;
                  default: v = 16'hFFFF;
               endcase
            end else begin
               v = 16'($urandom_range(16'hFFFF));
               // fold a high surrogate into a lone low one
               if (v >= HIGH_SURR_LO && v <= HIGH_SURR_HI) v = v ^ 16'h0400;
            end
            put_u_escape(v);
         end else begin
            case ($urandom_range(5))
               0: begin
                  put_u_escape(HIGH_SURR_LO);
                  put_u_escape(LOW_SURR_LO);
               end
               1: begin
                  put_u_escape(HIGH_SURR_HI);
                  put_u_escape(LOW_SURR_HI);
               end
               default: begin
                  put_u_escape(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
                  put_u_escape(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)));
               end
            endcase
         end
      end
      if ($urandom_range(99) >= 3) put_byte(CHAR_QUOTE);
   endtask

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_queued();
      while (text_q.size() > 0) begin
         send_byte(text_q.pop_front());
         bytes_sent++;
      end
   endtask

   task automatic send_strings(int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         build_string();
         send_queued();
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_text_byte = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      put_byte(CHAR_QUOTE);
      put_byte(8'hFF);
      put_u_escape(16'h0000);
      put_u_escape(HIGH_SURR_HI);
      put_u_escape(LOW_SURR_HI);
      put_byte(CHAR_QUOTE);
      put_byte("x");
      put_byte(CHAR_QUOTE);
      put_byte(8'h00);
      put_byte(CHAR_QUOTE);
      put_byte(CHAR_BSL);
      put_byte(CHAR_U);
      put_byte(8'h00);
      send_queued();

      send_strings(145);
      wait_drained();

      send_gap_pct = 72;
      recv_gap_pct = 34;
      send_strings(145);
      wait_drained();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      hold_off_req = 1'b1;
      send_strings(35);
      send_strings(105);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
